FILE: hdl/lta_pkg.sv
// Shared constants, types and codes of the lottery ticket arbiter.
`default_nettype none
package lta_pkg;

  localparam int MAX_PROCESSES    = 8;
  localparam int MAX_TICKETS_EACH = 15;

  localparam int KIND_W = 1;
  localparam int TKT_W  = 4;
  localparam int RND_W  = 16;
  localparam int ST_W   = 2;
  localparam int PN_W   = 8;
  localparam int TOT_W  = 7;
  localparam int OCC_W  = 4;

  localparam int IDX_W  = $clog2(MAX_PROCESSES);
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int PTR_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(RND_W + 1);

  localparam logic [KIND_W-1:0] KIND_ADD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_DRAW = 1'b1;

  localparam logic [PN_W-1:0] PN_FIRST = PN_W'(1);
  localparam logic [PN_W-1:0] PN_LAST  = PN_W'(255);

  typedef enum logic [ST_W-1:0] {
    ST_ADDED  = 2'd0,
    ST_SERVED = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [PN_W-1:0]  process;
    logic [TKT_W-1:0] tickets;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    entry_t            data;
  } ram_wr_t;

endpackage
`default_nettype wire

FILE: hdl/lta_if.sv
// Valid/ready channel interfaces for item and result words.
`default_nettype none
interface lta_in_if import lta_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TKT_W-1:0]  ticket_count;
  logic [RND_W-1:0]  random_value;

  modport source (output valid, kind, ticket_count, random_value, input ready);
  modport sink   (input valid, kind, ticket_count, random_value, output ready);
endinterface

interface lta_out_if import lta_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [PN_W-1:0]  process_number;
  logic [TOT_W-1:0] range_start;
  logic [TOT_W-1:0] range_end;
  logic [TOT_W-1:0] winning_ticket;
  logic [TOT_W-1:0] tickets_total;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, process_number, range_start, range_end,
                  winning_ticket, tickets_total, occupancy, input ready);
  modport sink   (input valid, status, process_number, range_start, range_end,
                  winning_ticket, tickets_total, occupancy, output ready);
endinterface
`default_nettype wire

FILE: hdl/lta_ram.sv
// Entry table memory: one write port, one registered read port.
`default_nettype none
module lta_ram import lta_pkg::*; (
  input  logic             clk,
  input  ram_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [MAX_PROCESSES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: hdl/lta_mod.sv
// Bit-serial remainder unit: random word modulo the ticket total.
`default_nettype none
module lta_mod import lta_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [TOT_W-1:0] divisor,
  output logic             done,
  output logic [TOT_W-1:0] remainder
);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [RND_W-1:0]  quo;
  logic [TOT_W-1:0] dvs;
  logic [TOT_W:0]   shifted;
  logic [TOT_W-1:0] remainder_next;

  always_comb begin
    shifted = {remainder, quo[RND_W-1]};
    if (shifted >= {1'b0, dvs}) begin
      remainder_next = TOT_W'(shifted - {1'b0, dvs});
    end else begin
      remainder_next = shifted[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= '0;
        quo <= dividend;
        dvs <= divisor;
        remainder <= '0;
      end else if (busy) begin
        remainder <= remainder_next;
        quo <= quo << 1;
        steps <= steps + STEP_W'(1);
        if (steps == STEP_W'(RND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lottery_ticket_arbiter_unit.sv
// Lottery ticket arbiter top level: sequencer over the entry table memory.
//
//  channel  dir  word                                               handshake
//  item     in   kind, ticket_count, random_value                   valid/ready
//  result   out  status, process_number, range_start, range_end,    valid/ready
//                winning_ticket, tickets_total, occupancy
//
// An add, a full add and an empty draw finish in the accept cycle; the result
// word is registered and shows in the next cycle. A served draw runs the
// bit-serial remainder of the random value by the ticket total, then a read
// and a compare per scanned entry, then a read and a write per shifted entry.
// Reset clears the sequencer, count, total and numbering; table contents
// are not cleared. A stalled result word blocks the next item.
`default_nettype none
module lottery_ticket_arbiter_unit import lta_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lta_in_if.sink    item,
  lta_out_if.source result
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MOD    = 7'b0000010,
    S_SC_RD  = 7'b0000100,
    S_SC_CMP = 7'b0001000,
    S_SH_RD  = 7'b0010000,
    S_SH_WR  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [TOT_W-1:0] total;
  logic [PN_W-1:0]  next_num;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] ptr;
  logic [TOT_W-1:0] base;
  logic [TOT_W-1:0] win;
  logic [PN_W-1:0]  sel_pn;
  logic [TOT_W-1:0] sel_rs;
  logic [TOT_W-1:0] sel_re;

  logic             res_valid;
  logic             res_load;
  status_t          res_status;
  logic [PN_W-1:0]  res_pn;
  logic [TOT_W-1:0] res_rs;
  logic [TOT_W-1:0] res_re;
  logic [TOT_W-1:0] res_win;
  logic [TOT_W-1:0] res_total;
  logic [OCC_W-1:0] res_occ;

  ram_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  logic             mod_start;
  logic             mod_done;
  logic [TOT_W-1:0] mod_rem;

  logic             out_free;
  logic             accept;
  logic             is_add;
  logic             full;
  logic             empty;
  logic [TKT_W-1:0] tkt;
  logic [TOT_W:0]   sum;
  logic             last;
  logic             hit;

  lta_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lta_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (item.random_value),
    .divisor   (total),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign out_free   = !res_valid || result.ready;
  assign item.ready = (state == S_IDLE) && out_free;
  assign accept     = item.valid && item.ready;
  assign is_add     = (item.kind == KIND_ADD);
  assign full       = (cnt == CNT_W'(MAX_PROCESSES));
  assign empty      = (cnt == '0);
  assign mod_start  = accept && !is_add && !empty;
  assign res_load   = ((state == S_IDLE) && accept && (is_add || empty)) ||
                      ((state == S_DONE) && out_free);

  always_comb begin
    if (item.ticket_count == '0) begin
      tkt = TKT_W'(1);
    end else if (int'(item.ticket_count) > MAX_TICKETS_EACH) begin
      tkt = TKT_W'(MAX_TICKETS_EACH);
    end else begin
      tkt = item.ticket_count;
    end
  end

  assign sum  = {1'b0, base} + (TOT_W + 1)'(rd_data.tickets);
  assign last = (CNT_W'(idx) == cnt - CNT_W'(1));
  assign hit  = ({1'b0, win} <= sum) || last;

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = ptr;
    wr.data = rd_data;
    rd_addr = idx;
    if (state == S_IDLE) begin
      wr.en           = accept && is_add && !full;
      wr.addr         = cnt[IDX_W-1:0];
      wr.data.process = next_num;
      wr.data.tickets = tkt;
    end else if (state == S_SH_WR) begin
      wr.en = 1'b1;
    end
    if (state == S_SH_RD) begin
      rd_addr = ptr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      total     <= '0;
      next_num  <= PN_FIRST;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_add && !full) begin
              res_status <= ST_ADDED;
              res_pn     <= next_num;
              res_rs     <= total + TOT_W'(1);
              res_re     <= total + TOT_W'(tkt);
              res_win    <= '0;
              res_total  <= total + TOT_W'(tkt);
              res_occ    <= OCC_W'(cnt + CNT_W'(1));
              cnt        <= cnt + CNT_W'(1);
              total      <= total + TOT_W'(tkt);
              next_num   <= (next_num == PN_LAST) ? PN_FIRST : next_num + PN_W'(1);
            end else if (is_add || empty) begin
              res_status <= is_add ? ST_FULL : ST_EMPTY;
              res_pn     <= '0;
              res_rs     <= '0;
              res_re     <= '0;
              res_win    <= '0;
              res_total  <= total;
              res_occ    <= OCC_W'(cnt);
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            win   <= mod_rem + TOT_W'(1);
            idx   <= '0;
            base  <= '0;
            state <= S_SC_RD;
          end
        end
        S_SC_RD: begin
          state <= S_SC_CMP;
        end
        S_SC_CMP: begin
          if (hit) begin
            sel_pn <= rd_data.process;
            sel_rs <= base + TOT_W'(1);
            sel_re <= sum[TOT_W-1:0];
            total  <= total - TOT_W'(rd_data.tickets);
            ptr    <= idx;
            if (PTR_W'(idx) + PTR_W'(1) < PTR_W'(cnt)) begin
              state <= S_SH_RD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            base  <= sum[TOT_W-1:0];
            idx   <= idx + IDX_W'(1);
            state <= S_SC_RD;
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          ptr <= ptr + IDX_W'(1);
          if (PTR_W'(ptr) + PTR_W'(2) < PTR_W'(cnt)) begin
            state <= S_SH_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_status <= ST_SERVED;
            res_pn     <= sel_pn;
            res_rs     <= sel_rs;
            res_re     <= sel_re;
            res_win    <= win;
            res_total  <= total;
            res_occ    <= OCC_W'(cnt - CNT_W'(1));
            cnt        <= cnt - CNT_W'(1);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid          = res_valid;
  assign result.status         = res_status;
  assign result.process_number = res_pn;
  assign result.range_start    = res_rs;
  assign result.range_end      = res_re;
  assign result.winning_ticket = res_win;
  assign result.tickets_total  = res_total;
  assign result.occupancy      = res_occ;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_PROCESSES))
    else $error("entry count beyond table depth");

  a_total_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (cnt == '0) == (total == '0))
    else $error("ticket total disagrees with entry count");

  a_win_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_SERVED |->
      res_win >= res_rs && res_win <= res_re)
    else $error("winning ticket outside the served range");

  a_mod_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_MOD && mod_done |=> state == S_SC_RD && idx == '0)
    else $error("scan did not start after remainder");

endmodule
`default_nettype wire
